@@ rtl/serial_line_escape_decoder_assert.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef SERIAL_LINE_ESCAPE_DECODER_ASSERT_SVH
`define SERIAL_LINE_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sled assertion failed");

// Next-cycle implication, checked outside reset.
`define SLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sled assertion failed");

`endif

@@ rtl/sled_pkg.sv @@
`timescale 1ns / 1ps

package sled_pkg;

  localparam logic [7:0] ChEsc  = 8'h1b;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChDel  = 8'h7f;
  localparam logic [7:0] ChBs   = 8'h08;
  localparam logic [7:0] ChO    = 8'h4f;
  localparam logic [7:0] ChBr   = 8'h5b;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChTilde = 8'h7e;
  localparam logic [7:0] ChA    = 8'h41;
  localparam logic [7:0] ChB    = 8'h42;
  localparam logic [7:0] ChC    = 8'h43;
  localparam logic [7:0] ChD    = 8'h44;
  localparam logic [7:0] ChF    = 8'h46;
  localparam logic [7:0] ChH    = 8'h48;

  typedef enum logic [2:0] {
    PFX_IDLE    = 3'd0,
    PFX_ESC     = 3'd1,
    PFX_ESC_O   = 3'd2,
    PFX_ESC_BR  = 3'd3,
    PFX_ESC_BR3 = 3'd4
  } prefix_e;

  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_UP     = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_LEFT   = 3'd3,
    KEY_RIGHT  = 3'd4,
    KEY_HOME   = 3'd5,
    KEY_END    = 3'd6,
    KEY_DELETE = 3'd7
  } key_e;

  // Decision for one byte: result, if any, and the next decoder state.
  typedef struct packed {
    logic       emit;
    logic [7:0] out_char;
    key_e       key_kind;
    prefix_e    prefix;
    logic       after_cr;
  } dec_t;

endpackage

@@ rtl/sled_byte_if.sv @@
`timescale 1ns / 1ps

interface sled_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sled_key_if.sv @@
`timescale 1ns / 1ps

interface sled_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] key_kind;

  modport source (output valid, output out_char, output key_kind, input ready);
  modport sink (input valid, input out_char, input key_kind, output ready);
endinterface

@@ rtl/sled_decode.sv @@
`timescale 1ns / 1ps

module sled_decode (
  input  logic [7:0]       rx_byte_i,
  input  sled_pkg::prefix_e prefix_i,
  input  logic             after_cr_i,
  output sled_pkg::dec_t   dec_o
);

  logic          seq_hit;   // byte completes a key
  logic          seq_ext;   // byte extends the prefix
  sled_pkg::key_e  seq_key;
  sled_pkg::prefix_e seq_pfx;

  // Match the byte against the current prefix.
  always_comb begin
    seq_hit = 1'b0;
    seq_ext = 1'b0;
    seq_key = sled_pkg::KEY_NONE;
    seq_pfx = sled_pkg::PFX_IDLE;
    case (prefix_i)
      sled_pkg::PFX_ESC: begin
        if (rx_byte_i == sled_pkg::ChO) begin
          seq_ext = 1'b1;
          seq_pfx = sled_pkg::PFX_ESC_O;
        end else if (rx_byte_i == sled_pkg::ChBr) begin
          seq_ext = 1'b1;
          seq_pfx = sled_pkg::PFX_ESC_BR;
        end
      end
      sled_pkg::PFX_ESC_O: begin
        if (rx_byte_i == sled_pkg::ChF) begin
          seq_hit = 1'b1;
          seq_key = sled_pkg::KEY_END;
        end else if (rx_byte_i == sled_pkg::ChH) begin
          seq_hit = 1'b1;
          seq_key = sled_pkg::KEY_HOME;
        end
      end
      sled_pkg::PFX_ESC_BR: begin
        case (rx_byte_i)
          sled_pkg::ChThree: begin
            seq_ext = 1'b1;
            seq_pfx = sled_pkg::PFX_ESC_BR3;
          end
          sled_pkg::ChA: begin
            seq_hit = 1'b1;
            seq_key = sled_pkg::KEY_UP;
          end
          sled_pkg::ChB: begin
            seq_hit = 1'b1;
            seq_key = sled_pkg::KEY_DOWN;
          end
          sled_pkg::ChC: begin
            seq_hit = 1'b1;
            seq_key = sled_pkg::KEY_RIGHT;
          end
          sled_pkg::ChD: begin
            seq_hit = 1'b1;
            seq_key = sled_pkg::KEY_LEFT;
          end
          sled_pkg::ChF: begin
            seq_hit = 1'b1;
            seq_key = sled_pkg::KEY_END;
          end
          sled_pkg::ChH: begin
            seq_hit = 1'b1;
            seq_key = sled_pkg::KEY_HOME;
          end
          default: begin
            seq_hit = 1'b0;
          end
        endcase
      end
      sled_pkg::PFX_ESC_BR3: begin
        if (rx_byte_i == sled_pkg::ChTilde) begin
          seq_hit = 1'b1;
          seq_key = sled_pkg::KEY_DELETE;
        end
      end
      default: begin
        seq_hit = 1'b0;
      end
    endcase
  end

  // Resolve the byte: key, prefix step, or ordinary character.
  always_comb begin
    dec_o.emit     = 1'b0;
    dec_o.out_char = 8'h00;
    dec_o.key_kind = sled_pkg::KEY_NONE;
    dec_o.prefix   = seq_pfx;
    dec_o.after_cr = after_cr_i;
    if (seq_ext) begin
      dec_o.emit = 1'b0;
    end else if (seq_hit) begin
      dec_o.emit     = 1'b1;
      dec_o.key_kind = seq_key;
      dec_o.after_cr = 1'b0;
    end else if (rx_byte_i == sled_pkg::ChEsc) begin
      dec_o.prefix = sled_pkg::PFX_ESC;
    end else if (rx_byte_i == sled_pkg::ChLf && after_cr_i) begin
      // drop the LF of a CR LF pair
      dec_o.after_cr = 1'b0;
    end else if (rx_byte_i == sled_pkg::ChCr) begin
      dec_o.emit     = 1'b1;
      dec_o.out_char = sled_pkg::ChLf;
      dec_o.after_cr = 1'b1;
    end else begin
      dec_o.emit     = 1'b1;
      dec_o.after_cr = 1'b0;
      dec_o.out_char = (rx_byte_i == sled_pkg::ChDel) ? sled_pkg::ChBs : rx_byte_i;
    end
  end

endmodule

@@ rtl/serial_line_escape_decoder.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// rx_i     in   valid/ready   rx_byte[7:0]
// key_o    out  valid/ready   out_char[7:0], key_kind[2:0]
//
// One byte per cycle sustained while key_o is not stalled. Each accepted
// byte waits in the input register and its result is then registered.
// Each byte is decided by the combinational decode logic between the input
// register and the result register, with the escape prefix and CR flag held
// in flops. Reset (rst_ni low, async) empties both registers and returns to
// idle with no prefix. A stall on key_o holds the result register and backs up
// into the input register; bytes that produce nothing still drain while stalled.

module serial_line_escape_decoder (
  input logic      clk_i,
  input logic      rst_ni,
  sled_byte_if.sink  rx_i,
  sled_key_if.source key_o
);

  // Input register: one received byte waiting for its decision.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // Decoder state.
  sled_pkg::prefix_e prefix_q;
  logic              cr_q;

  // Result register.
  logic           out_valid_q;
  logic [7:0]     out_char_q;
  sled_pkg::key_e out_key_q;

  sled_pkg::dec_t dec;
  logic           advance;

  sled_decode u_decode (
    .rx_byte_i (s1_byte_q),
    .prefix_i  (prefix_q),
    .after_cr_i(cr_q),
    .dec_o     (dec)
  );

  // Retire the held byte unless its result has nowhere to go.
  assign advance    = s1_valid_q && (!dec.emit || !out_valid_q || key_o.ready);
  assign rx_i.ready = !s1_valid_q || advance;

  assign key_o.valid    = out_valid_q;
  assign key_o.out_char = out_char_q;
  assign key_o.key_kind = out_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      prefix_q    <= sled_pkg::PFX_IDLE;
      cr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a new byte whenever the input register frees up.
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      // Commit the state step of the retired byte.
      if (advance) begin
        prefix_q <= dec.prefix;
        cr_q     <= dec.after_cr;
      end
      // Fill the result register, or empty it once the transaction is taken.
      if (advance && dec.emit) begin
        out_valid_q <= 1'b1;
      end else if (key_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      s1_byte_q <= rx_i.rx_byte;
    end
    if (advance && dec.emit) begin
      out_char_q <= dec.out_char;
      out_key_q  <= dec.key_kind;
    end
  end

`include "serial_line_escape_decoder_assert.svh"

  // A key code carries no character.
  `SLED_ASSERT_NOW(a_key_char_zero, clk_i, rst_ni,
                   out_valid_q && out_key_q != sled_pkg::KEY_NONE,
                   out_char_q == 8'h00)
  // A blocked byte stays put in the input register.
  `SLED_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !advance,
                    s1_valid_q && $stable(s1_byte_q))
  // The CR flag only rises together with an emitted LF.
  `SLED_ASSERT_NOW(a_cr_lf, clk_i, rst_ni, $rose(cr_q),
                   out_valid_q && out_char_q == sled_pkg::ChLf &&
                   out_key_q == sled_pkg::KEY_NONE)
  // ESC [ 3 is only reached from ESC [.
  `SLED_ASSERT_NOW(a_br3_from_br, clk_i, rst_ni,
                   prefix_q == sled_pkg::PFX_ESC_BR3 &&
                   $past(prefix_q) != sled_pkg::PFX_ESC_BR3,
                   $past(prefix_q) == sled_pkg::PFX_ESC_BR)

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // Run limits, in cycles unless marked otherwise.
  localparam int unsigned TIMEOUT_NS   = 4_000_000;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          PHASE_BYTES  = 150;
  localparam int          NUM_PHASES   = 6;

  // Receiver behavior on key_o, switched per phase.
  typedef enum int {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_BURSTY
  } sink_mode_e;

  // One expected result on key_o.
  typedef struct packed {
    logic [7:0]     ch;
    sled_pkg::key_e kind;
  } key_result_t;

  // Tracks the decoder state on the side, predicts the result of each
  // accepted byte and checks the results that come out in order.
  class key_scoreboard;
    sled_pkg::prefix_e pfx;
    bit                after_cr;
    key_result_t       pending_keys[$];
    int                errors;
    int                bytes_seen;
    int                keys_checked;
    int                kinds_seen[8];

    function new();
      pfx          = sled_pkg::PFX_IDLE;
      after_cr     = 1'b0;
      errors       = 0;
      bytes_seen   = 0;
      keys_checked = 0;
      foreach (kinds_seen[i]) kinds_seen[i] = 0;
    endfunction

    // Advance the prefix state with one accepted byte and queue its result.
    function void note_byte(input logic [7:0] b);
      sled_pkg::prefix_e p;
      sled_pkg::key_e    k;
      bit                consumed;
      logic [7:0]        c;
      key_result_t       r;
      p        = pfx;
      pfx      = sled_pkg::PFX_IDLE;
      k        = sled_pkg::KEY_NONE;
      consumed = 1'b0;
      bytes_seen++;
      case (p)
        sled_pkg::PFX_ESC: begin
          if (b == sled_pkg::ChO) begin
            pfx = sled_pkg::PFX_ESC_O;
            consumed = 1'b1;
          end else if (b == sled_pkg::ChBr) begin
            pfx = sled_pkg::PFX_ESC_BR;
            consumed = 1'b1;
          end
        end
        sled_pkg::PFX_ESC_O: begin
          if (b == sled_pkg::ChF) k = sled_pkg::KEY_END;
          else if (b == sled_pkg::ChH) k = sled_pkg::KEY_HOME;
        end
        sled_pkg::PFX_ESC_BR: begin
          case (b)
            sled_pkg::ChThree: begin
              pfx = sled_pkg::PFX_ESC_BR3;
              consumed = 1'b1;
            end
            sled_pkg::ChA: k = sled_pkg::KEY_UP;
            sled_pkg::ChB: k = sled_pkg::KEY_DOWN;
            sled_pkg::ChC: k = sled_pkg::KEY_RIGHT;
            sled_pkg::ChD: k = sled_pkg::KEY_LEFT;
            sled_pkg::ChF: k = sled_pkg::KEY_END;
            sled_pkg::ChH: k = sled_pkg::KEY_HOME;
            default: ;
          endcase
        end
        sled_pkg::PFX_ESC_BR3: begin
          if (b == sled_pkg::ChTilde) k = sled_pkg::KEY_DELETE;
        end
        default: ;
      endcase
      if (consumed) return;
      if (k != sled_pkg::KEY_NONE) begin
        after_cr = 1'b0;
        r.ch     = 8'h00;
        r.kind   = k;
        pending_keys.push_back(r);
        return;
      end
      // Not part of a sequence: handle as an ordinary byte.
      if (b == sled_pkg::ChEsc) begin
        pfx = sled_pkg::PFX_ESC;
        return;
      end
      if (b == sled_pkg::ChLf && after_cr) begin
        after_cr = 1'b0;
        return;
      end
      c = b;
      if (b == sled_pkg::ChCr) begin
        c = sled_pkg::ChLf;
        after_cr = 1'b1;
      end else begin
        after_cr = 1'b0;
      end
      if (c == sled_pkg::ChDel) c = sled_pkg::ChBs;
      r.ch   = c;
      r.kind = sled_pkg::KEY_NONE;
      pending_keys.push_back(r);
    endfunction

    // Compare one result transaction against the oldest expectation.
    function void check_key(input logic [7:0] ch, input logic [2:0] kind);
      key_result_t e;
      if (pending_keys.size() == 0) begin
        errors++;
        $display("%0t: unexpected result char=%02h kind=%0d", $time, ch, kind);
        return;
      end
      e = pending_keys.pop_front();
      keys_checked++;
      kinds_seen[e.kind]++;
      if (ch !== e.ch || kind !== e.kind) begin
        errors++;
        $display("%0t: mismatch expected char=%02h kind=%0d, actual char=%02h kind=%0d",
                 $time, e.ch, e.kind, ch, kind);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sled_byte_if rx ();
  sled_key_if  key ();

  serial_line_escape_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx.sink),
    .key_o  (key.source)
  );

  key_scoreboard sb = new();

  // Sender pacing: bursts of random length, random gaps up to gap_max.
  int         burst_left = 0;
  int         gap_max    = 0;
  // Receiver pacing and the long hold-off.
  sink_mode_e sink_mode  = SINK_ALWAYS;
  bit         hold_req   = 1'b0;
  int         hold_left  = 0;
  int         stall_left = 0;
  int         sink_cycle = 0;
  int         holdoffs   = 0;
  int         rx_stalls  = 0;

  always #6 clk_i = ~clk_i;

  // Receiver: drop ready on its own pattern; a hold-off request overrides
  // the pattern and holds ready low while hold_left counts it down here.
  always @(posedge clk_i) begin
    sink_cycle++;
    if (hold_left > 0) begin
      key.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      holdoffs++;
      key.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_ALWAYS:  key.ready <= 1'b1;
        SINK_RANDOM:  key.ready <= ($urandom_range(0, 99) >= 35);
        SINK_PATTERN: key.ready <= ((sink_cycle % 9) < 5);
        SINK_BURSTY: begin
          if (stall_left > 0) begin
            key.ready <= 1'b0;
            stall_left--;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(2, 12);
            key.ready <= 1'b0;
          end else begin
            key.ready <= 1'b1;
          end
        end
        default: key.ready <= 1'b1;
      endcase
    end
  end

  // Monitor: check every result transaction and count input back-pressure.
  // Values read here are the ones that stood before this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (key.valid && key.ready) sb.check_key(key.out_char, key.key_kind);
      if (rx.valid && !rx.ready) rx_stalls++;
    end
  end

  // Offer one byte and hold it until the transaction completes. A new burst
  // may start with a gap, during which valid is dropped.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    sb.note_byte(b);
    burst_left--;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Pause the sender until every expected result has come out or DRAIN_LIMIT runs out.
  task automatic wait_drained();
    int waited;
    waited = 0;
    rx.valid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.pending_keys.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  // Byte that follows a prefix in a broken sequence: often one of the
  // bytes with a meaning of its own, otherwise anything.
  function automatic logic [7:0] tail_byte();
    case ($urandom_range(0, 7))
      0: return sled_pkg::ChEsc;
      1: return sled_pkg::ChCr;
      2: return sled_pkg::ChLf;
      3: return sled_pkg::ChDel;
      4: return sled_pkg::ChO;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one random chunk: half the time a well-formed key sequence, else
  // line endings, plain text, broken sequences or raw noise.
  task automatic send_random_sequence();
    logic [7:0] seq[$];
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      case ($urandom_range(0, 8))
        0: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChA};
        1: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChB};
        2: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChC};
        3: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChD};
        4: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChH};
        5: seq = '{sled_pkg::ChEsc, sled_pkg::ChO, sled_pkg::ChH};
        6: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChF};
        7: seq = '{sled_pkg::ChEsc, sled_pkg::ChO, sled_pkg::ChF};
        default: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChThree,
                          sled_pkg::ChTilde};
      endcase
    end else if (pick < 62) begin
      case ($urandom_range(0, 3))
        0: seq = '{sled_pkg::ChCr, sled_pkg::ChLf};
        1: seq = '{sled_pkg::ChCr};
        2: seq = '{sled_pkg::ChLf};
        default: seq = '{sled_pkg::ChCr, sled_pkg::ChCr, sled_pkg::ChLf,
                          sled_pkg::ChLf};
      endcase
    end else if (pick < 75) begin
      n = $urandom_range(1, 4);
      repeat (n) seq.push_back(8'($urandom_range(8'h20, 8'h7f)));
    end else if (pick < 87) begin
      case ($urandom_range(0, 3))
        0: seq = '{sled_pkg::ChEsc};
        1: seq = '{sled_pkg::ChEsc, sled_pkg::ChO};
        2: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr};
        default: seq = '{sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChThree};
      endcase
      seq.push_back(tail_byte());
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    send_bytes(seq);
  endtask

  initial begin
    logic [7:0] directed[$];
    int         target;
    // Drive known values before the first edge.
    rst_ni     <= 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, each kind of sequence, CR/LF folding, DEL,
    // a prefix broken by CR and an ESC that restarts a pending prefix.
    sink_mode = SINK_ALWAYS;
    gap_max   = 0;
    directed  = '{8'h00, 8'hff,
                  sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChA,
                  sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChThree, sled_pkg::ChTilde,
                  sled_pkg::ChEsc, sled_pkg::ChO, sled_pkg::ChH,
                  sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChF,
                  sled_pkg::ChCr, sled_pkg::ChLf, sled_pkg::ChLf,
                  sled_pkg::ChDel,
                  sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChThree, sled_pkg::ChCr,
                  sled_pkg::ChEsc, sled_pkg::ChEsc, sled_pkg::ChBr, sled_pkg::ChD};
    send_bytes(directed);
    wait_drained();

    // Random phases; each one sets the pacing on both sides and ends with the
    // sender paused until all results are in or DRAIN_LIMIT runs out.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin sink_mode = SINK_ALWAYS;  gap_max = 0; end
        1: begin sink_mode = SINK_RANDOM;  gap_max = 4; end
        2: begin sink_mode = SINK_PATTERN; gap_max = 8; end
        3: begin sink_mode = SINK_RANDOM;  gap_max = 0; end
        4: begin sink_mode = SINK_BURSTY;  gap_max = 3; end
        default: begin sink_mode = SINK_RANDOM; gap_max = 6; end
      endcase
      target = sb.bytes_seen + PHASE_BYTES;
      // Phase 3: hold the receiver off while plain bytes keep coming, so the
      // decoder fills and stalls its input.
      if (phase == 3) begin
        hold_req = 1'b1;
        repeat (40) send_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      while (sb.bytes_seen < target) begin
        if (phase == NUM_PHASES - 1 && sb.bytes_seen == target - PHASE_BYTES / 2)
          hold_req = 1'b1;
        send_random_sequence();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_keys.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived, first char=%02h kind=%0d",
               $time, sb.pending_keys.size(), sb.pending_keys[0].ch,
               sb.pending_keys[0].kind);
    end

    $display("Decoder run: %0d bytes accepted, %0d results checked, %0d input stall cycles,",
             sb.bytes_seen, sb.keys_checked, rx_stalls);
    $display("  %0d hold-offs; plain/up/down/left/right/home/end/delete: %0d %0d %0d %0d %0d %0d %0d %0d",
             holdoffs, sb.kinds_seen[0], sb.kinds_seen[1], sb.kinds_seen[2],
             sb.kinds_seen[3], sb.kinds_seen[4], sb.kinds_seen[5], sb.kinds_seen[6],
             sb.kinds_seen[7]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results still expected", sb.pending_keys.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sled_pkg.sv
rtl/sled_byte_if.sv
rtl/sled_key_if.sv
rtl/sled_decode.sv
rtl/serial_line_escape_decoder.sv
test/testbench.sv
